/* rtl/core/ifb_pkg.sv */
`default_nettype none

package ifb_pkg;

    // Fixed field widths of the sample and result items, the sequencer and the datapath.
    localparam int unsigned DATA_W    = 32;
    localparam int unsigned IN_W      = 6 * DATA_W;
    localparam int unsigned OUT_W     = 3 * DATA_W;
    localparam int unsigned AXIS_W    = 2;
    localparam int unsigned STEP_W    = 4;
    localparam int unsigned PROD_W    = 63;
    localparam int unsigned ACC_W     = 66;
    localparam int unsigned RND_W     = ACC_W - 16;
    localparam int unsigned GAIN_W    = 17;
    localparam int unsigned OPB_W     = 31;
    localparam int unsigned APB_AW    = 5;

    localparam logic [GAIN_W-1:0] ONE_Q16 = 17'd65536;
    localparam logic [ACC_W-1:0]  HALF_Q16 = 66'd32768;

    // Register reset values.
    localparam logic [2:0]        RST_MODE    = 3'd4;
    localparam logic [15:0]       RST_PERIOD  = 16'd328;
    localparam logic [GAIN_W-1:0] RST_LP_GAIN = 17'd0;
    localparam logic [GAIN_W-1:0] RST_HP_GAIN = 17'd65536;
    localparam logic [GAIN_W-1:0] RST_LEAK    = 17'd65536;
    localparam logic [GAIN_W-1:0] RST_BLEND   = 17'd0;
    localparam logic [OPB_W-1:0]  RST_LEVER   = 31'd65536;

    typedef enum logic [2:0] {
        MODE_LOWPASS  = 3'd0,
        MODE_HIGHPASS = 3'd1,
        MODE_INTEGRAL = 3'd2,
        MODE_LEAKY    = 3'd3,
        MODE_COMPL    = 3'd4
    } t_mode;

    typedef enum logic [2:0] {
        REG_MODE    = 3'd0,
        REG_PERIOD  = 3'd1,
        REG_LP_GAIN = 3'd2,
        REG_HP_GAIN = 3'd3,
        REG_LEAK    = 3'd4,
        REG_BLEND   = 3'd5,
        REG_LEVER   = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic [2:0]        mode;
        logic [15:0]       period;
        logic [GAIN_W-1:0] lp_gain;
        logic [GAIN_W-1:0] hp_gain;
        logic [GAIN_W-1:0] leak;
        logic [GAIN_W-1:0] blend;
        logic [OPB_W-1:0]  lever;
    } t_cfg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FINISH
    } t_state;

    typedef enum logic [1:0] {
        OP_NOP,
        OP_MUL,
        OP_FIN,
        OP_FIN_P
    } t_op;

    typedef enum logic [3:0] {
        A_ACC,
        A_GYR,
        A_GYR_NEXT,
        A_LP,
        A_HP_IN,
        A_HP_OUT,
        A_PLAIN,
        A_P_LO,
        A_P_HI,
        A_VI
    } t_asel;

    typedef enum logic [3:0] {
        B_T,
        B_G,
        B_G_INV,
        B_H,
        B_K,
        B_W,
        B_W_INV,
        B_LEVER,
        B_ONE
    } t_bsel;

    // One micro-instruction of the shared multiply-accumulate datapath.
    typedef struct packed {
        t_op   op;
        t_asel asel;
        t_bsel bsel;
        logic  clr;
        logic  sub;
        logic  sh24;
        logic  wr_lp;
        logic  wr_hp_in;
        logic  wr_hp_out;
        logic  wr_plain;
        logic  wr_vi;
        logic  wr_res;
        logic  last;
    } t_ucmd;

    typedef struct packed {
        logic              load_in;
        logic              load_out;
        logic [AXIS_W-1:0] axis;
        t_ucmd             cmd;
    } t_dp_ctrl;

    function automatic t_ucmd f_nop();
        t_ucmd c;
        c.op        = OP_NOP;
        c.asel      = A_ACC;
        c.bsel      = B_T;
        c.clr       = 1'b0;
        c.sub       = 1'b0;
        c.sh24      = 1'b0;
        c.wr_lp     = 1'b0;
        c.wr_hp_in  = 1'b0;
        c.wr_hp_out = 1'b0;
        c.wr_plain  = 1'b0;
        c.wr_vi     = 1'b0;
        c.wr_res    = 1'b0;
        c.last      = 1'b0;
        return c;
    endfunction

    function automatic t_ucmd f_mul(t_asel a, t_bsel b, logic clr, logic sub, logic sh24);
        t_ucmd c;
        c      = f_nop();
        c.op   = OP_MUL;
        c.asel = a;
        c.bsel = b;
        c.clr  = clr;
        c.sub  = sub;
        c.sh24 = sh24;
        return c;
    endfunction

    function automatic t_ucmd f_fin(logic lp, logic hp_in, logic hp_out, logic plain,
                                    logic vi, logic last);
        t_ucmd c;
        c           = f_nop();
        c.op        = OP_FIN;
        c.wr_lp     = lp;
        c.wr_hp_in  = hp_in;
        c.wr_hp_out = hp_out;
        c.wr_plain  = plain;
        c.wr_vi     = vi;
        c.wr_res    = last;
        c.last      = last;
        return c;
    endfunction

    function automatic t_ucmd f_fin_p();
        t_ucmd c;
        c    = f_nop();
        c.op = OP_FIN_P;
        return c;
    endfunction

    // Per-axis programme of each filter. A product is accumulated in the cycle
    // after its multiply, so a quiet step precedes each rounding step.
    function automatic t_ucmd f_ucode(logic [2:0] mode, logic [STEP_W-1:0] step);
        t_ucmd c;
        c = f_nop();
        case (mode)
            MODE_LOWPASS: begin
                case (step)
                    4'd0:    c = f_mul(A_LP, B_G_INV, 1'b1, 1'b0, 1'b0);
                    4'd1:    c = f_mul(A_GYR, B_G, 1'b0, 1'b0, 1'b0);
                    4'd3:    c = f_fin(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
                    default: c = f_nop();
                endcase
            end
            MODE_HIGHPASS: begin
                case (step)
                    4'd0:    c = f_mul(A_HP_OUT, B_H, 1'b1, 1'b0, 1'b0);
                    4'd1:    c = f_mul(A_ACC, B_H, 1'b0, 1'b0, 1'b0);
                    4'd2:    c = f_mul(A_HP_IN, B_H, 1'b0, 1'b1, 1'b0);
                    4'd4:    c = f_fin(1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1);
                    default: c = f_nop();
                endcase
            end
            MODE_INTEGRAL: begin
                case (step)
                    4'd0:    c = f_mul(A_ACC, B_T, 1'b1, 1'b0, 1'b0);
                    4'd1:    c = f_mul(A_PLAIN, B_ONE, 1'b0, 1'b0, 1'b0);
                    4'd3:    c = f_fin(1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1);
                    default: c = f_nop();
                endcase
            end
            MODE_LEAKY: begin
                case (step)
                    4'd0:    c = f_mul(A_HP_OUT, B_K, 1'b1, 1'b0, 1'b0);
                    4'd1:    c = f_mul(A_ACC, B_T, 1'b0, 1'b0, 1'b0);
                    4'd3:    c = f_fin(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1);
                    default: c = f_nop();
                endcase
            end
            MODE_COMPL: begin
                case (step)
                    4'd0:    c = f_mul(A_HP_OUT, B_K, 1'b1, 1'b0, 1'b0);
                    4'd1:    c = f_mul(A_ACC, B_T, 1'b0, 1'b0, 1'b0);
                    4'd3:    c = f_fin(1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0);
                    4'd4:    c = f_mul(A_GYR_NEXT, B_LEVER, 1'b1, 1'b0, 1'b0);
                    4'd6:    c = f_fin_p();
                    4'd7:    c = f_mul(A_P_LO, B_W, 1'b1, 1'b0, 1'b0);
                    4'd8:    c = f_mul(A_P_HI, B_W, 1'b0, 1'b0, 1'b1);
                    4'd9:    c = f_mul(A_VI, B_W_INV, 1'b0, 1'b0, 1'b0);
                    4'd11:   c = f_fin(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
                    default: c = f_nop();
                endcase
            end
            default: c = f_nop();
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/ifb_cfg_regs.sv */
`default_nettype none

module ifb_cfg_regs (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [ifb_pkg::APB_AW-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    output logic      [31:0]                prdata,
    output logic                            pready,
    output ifb_pkg::t_cfg                   o_cfg
);
    import ifb_pkg::*;

    t_cfg       r_cfg;
    logic       wr_en;
    logic [2:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[APB_AW-1:2];
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode    <= RST_MODE;
            r_cfg.period  <= RST_PERIOD;
            r_cfg.lp_gain <= RST_LP_GAIN;
            r_cfg.hp_gain <= RST_HP_GAIN;
            r_cfg.leak    <= RST_LEAK;
            r_cfg.blend   <= RST_BLEND;
            r_cfg.lever   <= RST_LEVER;
        end else if (wr_en) begin
            case (idx)
                REG_MODE:    r_cfg.mode    <= pwdata[2:0];
                REG_PERIOD:  r_cfg.period  <= pwdata[15:0];
                REG_LP_GAIN: r_cfg.lp_gain <= pwdata[GAIN_W-1:0];
                REG_HP_GAIN: r_cfg.hp_gain <= pwdata[GAIN_W-1:0];
                REG_LEAK:    r_cfg.leak    <= pwdata[GAIN_W-1:0];
                REG_BLEND:   r_cfg.blend   <= pwdata[GAIN_W-1:0];
                REG_LEVER:   r_cfg.lever   <= pwdata[OPB_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_MODE:    prdata = {29'd0, r_cfg.mode};
            REG_PERIOD:  prdata = {16'd0, r_cfg.period};
            REG_LP_GAIN: prdata = {15'd0, r_cfg.lp_gain};
            REG_HP_GAIN: prdata = {15'd0, r_cfg.hp_gain};
            REG_LEAK:    prdata = {15'd0, r_cfg.leak};
            REG_BLEND:   prdata = {15'd0, r_cfg.blend};
            REG_LEVER:   prdata = {1'b0, r_cfg.lever};
            default:     prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

/* rtl/core/ifb_ctrl.sv */
`default_nettype none

module ifb_ctrl #(
    parameter int unsigned AXES = 3
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic [2:0] i_mode,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output ifb_pkg::t_dp_ctrl o_ctrl
);
    import ifb_pkg::*;

    t_state              r_state, n_state;
    logic [STEP_W-1:0]   r_step, n_step;
    logic [AXIS_W-1:0]   r_axis, n_axis;
    logic                r_out_valid, n_out_valid;
    t_ucmd               cmd;
    logic                mode_ok;
    logic                out_free;

    assign cmd      = f_ucode(i_mode, r_step);
    assign mode_ok  = i_mode inside {[MODE_LOWPASS:MODE_COMPL]};
    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_axis      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_axis      <= n_axis;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and sequencing counters.
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_axis  = r_axis;
        case (r_state)
            ST_IDLE: begin
                n_step = '0;
                n_axis = '0;
                if (i_in_valid) begin
                    n_state = mode_ok ? ST_RUN : ST_FINISH;
                end
            end
            ST_RUN: begin
                if (cmd.last) begin
                    n_step = '0;
                    if (r_axis == AXIS_W'(AXES - 1)) begin
                        n_state = ST_FINISH;
                    end else begin
                        n_axis = r_axis + 1'b1;
                    end
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Commands to the datapath and handshake outputs.
    always_comb begin
        o_in_ready      = (r_state == ST_IDLE);
        o_out_valid     = r_out_valid;
        o_ctrl.load_in  = (r_state == ST_IDLE) && i_in_valid;
        o_ctrl.load_out = (r_state == ST_FINISH) && out_free;
        o_ctrl.axis     = r_axis;
        o_ctrl.cmd      = (r_state == ST_RUN) ? cmd : f_nop();
        if (o_ctrl.load_out) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/ifb_datapath.sv */
`default_nettype none

module ifb_datapath #(
    parameter int unsigned AXES = 3
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire ifb_pkg::t_cfg              i_cfg,
    input  wire ifb_pkg::t_dp_ctrl          i_ctrl,
    input  wire logic [ifb_pkg::IN_W-1:0]   i_in_data,
    output logic      [ifb_pkg::OUT_W-1:0]  o_out_data,
    output logic                            o_out_sat
);
    import ifb_pkg::*;

    localparam int unsigned AW = (AXES > 1) ? $clog2(AXES) : 1;

    typedef struct packed {
        logic en;
        logic clr;
        logic sub;
        logic sh24;
    } t_acc_ctl;

    logic signed [DATA_W-1:0] r_accel [3];
    logic signed [DATA_W-1:0] r_gyro  [3];
    logic signed [DATA_W-1:0] r_lp     [AXES];
    logic signed [DATA_W-1:0] r_hp_in  [AXES];
    logic signed [DATA_W-1:0] r_hp_out [AXES];
    logic signed [DATA_W-1:0] r_plain  [AXES];
    logic signed [DATA_W-1:0] r_res [3];
    logic signed [DATA_W-1:0] r_out [3];
    logic signed [DATA_W-1:0] r_vi;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [RND_W-1:0]  r_p;
    logic                     r_sat;
    logic                     r_out_sat;
    t_acc_ctl                 r_pend;

    t_ucmd                    cmd;
    logic [AXIS_W-1:0]        ax;
    logic [AW-1:0]            sx;
    logic [AXIS_W-1:0]        ax_next;
    logic signed [DATA_W-1:0] op_a;
    logic [OPB_W-1:0]         op_b;
    logic signed [63:0]       mul_full;
    logic [GAIN_W-1:0]        g_c, h_c, k_c, w_c;
    logic signed [ACC_W-1:0]  term;
    logic signed [ACC_W-1:0]  base;
    logic signed [ACC_W-1:0]  rsum;
    logic signed [RND_W-1:0]  rnd;
    logic                     sat_hi, sat_lo;
    logic signed [DATA_W-1:0] clipped;

    function automatic logic [GAIN_W-1:0] f_clamp(logic [GAIN_W-1:0] g);
        return (g > ONE_Q16) ? ONE_Q16 : g;
    endfunction

    assign cmd = i_ctrl.cmd;
    assign ax  = i_ctrl.axis;
    assign sx  = ax[AW-1:0];
    assign g_c = f_clamp(i_cfg.lp_gain);
    assign h_c = f_clamp(i_cfg.hp_gain);
    assign k_c = f_clamp(i_cfg.leak);
    assign w_c = f_clamp(i_cfg.blend);

    // Lever-arm term pairs each velocity axis with the following gyro axis.
    always_comb begin
        case (ax)
            2'd0:    ax_next = 2'd1;
            2'd1:    ax_next = 2'd2;
            default: ax_next = 2'd0;
        endcase
    end

    always_comb begin
        case (cmd.asel)
            A_ACC:      op_a = r_accel[ax];
            A_GYR:      op_a = r_gyro[ax];
            A_GYR_NEXT: op_a = r_gyro[ax_next];
            A_LP:       op_a = r_lp[sx];
            A_HP_IN:    op_a = r_hp_in[sx];
            A_HP_OUT:   op_a = r_hp_out[sx];
            A_PLAIN:    op_a = r_plain[sx];
            A_P_LO:     op_a = {8'd0, r_p[23:0]};
            A_P_HI:     op_a = DATA_W'(r_p >>> 24);
            A_VI:       op_a = r_vi;
            default:    op_a = '0;
        endcase
    end

    always_comb begin
        case (cmd.bsel)
            B_T:     op_b = {15'd0, i_cfg.period};
            B_G:     op_b = {14'd0, g_c};
            B_G_INV: op_b = {14'd0, ONE_Q16 - g_c};
            B_H:     op_b = {14'd0, h_c};
            B_K:     op_b = {14'd0, k_c};
            B_W:     op_b = {14'd0, w_c};
            B_W_INV: op_b = {14'd0, ONE_Q16 - w_c};
            B_LEVER: op_b = i_cfg.lever;
            B_ONE:   op_b = {14'd0, ONE_Q16};
            default: op_b = '0;
        endcase
    end

    assign mul_full = 64'(op_a) * 64'($signed({1'b0, op_b}));

    // Accumulate the product registered in the previous cycle.
    always_comb begin
        if (r_pend.sh24) begin
            term = {r_prod[ACC_W-25:0], 24'd0};
        end else begin
            term = ACC_W'(r_prod);
        end
        base = r_pend.clr ? '0 : r_acc;
    end

    // Round half up to Q16.16, then clip to 32 bits.
    always_comb begin
        rsum    = r_acc + $signed(HALF_Q16);
        rnd     = rsum[ACC_W-1:16];
        sat_hi  = !rnd[RND_W-1] && (|rnd[RND_W-2:DATA_W-1]);
        sat_lo  = rnd[RND_W-1] && !(&rnd[RND_W-2:DATA_W-1]);
        if (sat_hi) begin
            clipped = {1'b0, {(DATA_W-1){1'b1}}};
        end else if (sat_lo) begin
            clipped = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            clipped = rnd[DATA_W-1:0];
        end
    end

    // Filter state: the only payload that reset has to clear.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < AXES; i++) begin
                r_lp[i]     <= '0;
                r_hp_in[i]  <= '0;
                r_hp_out[i] <= '0;
                r_plain[i]  <= '0;
            end
            r_pend <= '0;
        end else begin
            r_pend.en   <= (cmd.op == OP_MUL);
            r_pend.clr  <= cmd.clr;
            r_pend.sub  <= cmd.sub;
            r_pend.sh24 <= cmd.sh24;
            if (cmd.op == OP_FIN) begin
                if (cmd.wr_lp) begin
                    r_lp[sx] <= clipped;
                end
                if (cmd.wr_hp_in) begin
                    r_hp_in[sx] <= r_accel[ax];
                end
                if (cmd.wr_hp_out) begin
                    r_hp_out[sx] <= clipped;
                end
                if (cmd.wr_plain) begin
                    r_plain[sx] <= clipped;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_in) begin
            for (int i = 0; i < 3; i++) begin
                r_accel[i] <= i_in_data[i*DATA_W +: DATA_W];
                r_gyro[i]  <= i_in_data[(i+3)*DATA_W +: DATA_W];
                r_res[i]   <= '0;
            end
            r_sat <= 1'b0;
        end else if (cmd.op == OP_FIN) begin
            r_sat <= r_sat | sat_hi | sat_lo;
            if (cmd.wr_res) begin
                r_res[ax] <= clipped;
            end
        end
        if (cmd.op == OP_MUL) begin
            r_prod <= mul_full[PROD_W-1:0];
        end
        if (r_pend.en) begin
            r_acc <= r_pend.sub ? (base - term) : (base + term);
        end
        if (cmd.op == OP_FIN_P) begin
            r_p <= rnd;
        end
        if ((cmd.op == OP_FIN) && cmd.wr_vi) begin
            r_vi <= clipped;
        end
        if (i_ctrl.load_out) begin
            r_out     <= r_res;
            r_out_sat <= r_sat;
        end
    end

    assign o_out_data = {r_out[2], r_out[1], r_out[0]};
    assign o_out_sat  = r_out_sat;

endmodule

`default_nettype wire

/* rtl/core/imu_axis_filter_bank.sv */
// Channel     Direction  Handshake                       Contents
// s_axis      in         i_s_axis_tvalid/o_s_axis_tready one IMU sample item
// m_axis      out        o_m_axis_tvalid/i_m_axis_tready one filtered result item
// APB         in/out     psel, penable, pwrite, pready   filter configuration
//
// Each accepted item runs the selected filter's per-axis programme over the AXES axes in
// turn: 4 steps for low-pass, integral and leaky integral, 5 for high-pass, 12 for the
// complementary blend, all on the one shared 32 by 31 bit multiplier. The next item is
// accepted once the last one is in the result register. An undefined mode gives an
// all-zero result. Reset is synchronous, active low, and clears control and filter
// state. A waiting result stalls only the finish of the next item, never its acceptance.
`default_nettype none

module imu_axis_filter_bank #(
    parameter int unsigned AXES = 3
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    // Sample stream.
    input  wire logic                       i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z, 32 bits each from bit 0 up
    input  wire logic [ifb_pkg::IN_W-1:0]   i_s_axis_tdata,
    // Result stream.
    output logic                            o_m_axis_tvalid,
    input  wire logic                       i_m_axis_tready,
    // out_x, out_y, out_z, 32 bits each from bit 0 up
    output logic      [ifb_pkg::OUT_W-1:0]  o_m_axis_tdata,
    // saturated in bit 0
    output logic      [0:0]                 o_m_axis_tuser,
    // Configuration port.
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [ifb_pkg::APB_AW-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    output logic      [31:0]                prdata,
    output logic                            pready
);
    import ifb_pkg::*;

    t_cfg     cfg;
    t_dp_ctrl dp_ctrl;
    logic     out_sat;

    // Register file: mode, sample period, gains, lever arm.
    ifb_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Sequencer: walks the selected filter's programme over each axis in turn and
    // hands the finished item to the output register.
    ifb_ctrl #(
        .AXES (AXES)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mode      (cfg.mode),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_ctrl      (dp_ctrl)
    );

    // Multiply-accumulate datapath with round-and-clip, filter state per axis,
    // and the output register.
    ifb_datapath #(
        .AXES (AXES)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_ctrl     (dp_ctrl),
        .i_in_data  (i_s_axis_tdata),
        .o_out_data (o_m_axis_tdata),
        .o_out_sat  (out_sat)
    );

    assign o_m_axis_tuser = out_sat;

endmodule

`default_nettype wire

/* rtl/core/ifb_checker.sv */
`default_nettype none

module ifb_checker (
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      i_s_axis_tvalid,
    input wire logic                      o_s_axis_tready,
    input wire logic                      o_m_axis_tvalid,
    input wire logic                      i_m_axis_tready,
    input wire logic [ifb_pkg::OUT_W-1:0] o_m_axis_tdata,
    input wire logic [0:0]                o_m_axis_tuser
);

    // A waiting result stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("result withdrawn while stalled");

    // A waiting result keeps its contents.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> $stable(o_m_axis_tdata) &&
        $stable(o_m_axis_tuser))
        else $error("result changed while stalled");

    // The block works on one sample at a time.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("second sample taken while busy");

    // A new result only appears after the block has been busy, never straight out of idle.
    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> !$past(o_s_axis_tready))
        else $error("result appeared without a busy cycle");

endmodule

bind imu_axis_filter_bank ifb_checker u_ifb_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

`default_nettype wire
